FILE: design/topk_accuracy_counter_unit_assert.svh
// assertion macros for the top-k accuracy counter
`ifndef TOPK_ACCURACY_COUNTER_UNIT_ASSERT_SVH
`define TOPK_ACCURACY_COUNTER_UNIT_ASSERT_SVH
// property that must hold at every clock edge outside reset
`define TKA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define TKA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/tka_pkg.sv
// ---------------------------------------------------------------------------
// tka_pkg
// shared types and codes of the top-k accuracy counter
// ---------------------------------------------------------------------------
`default_nettype none
package tka_pkg;
    localparam int FIELD_W = 6;
    localparam int RATIO_W = 17;
    localparam logic [FIELD_W-1:0] TOPK_RESET = 6'd1;
    localparam logic [FIELD_W-1:0] NCLS_RESET = 6'd16;

    typedef enum logic {
        OP_SCORE  = 1'b0,
        OP_REPORT = 1'b1
    } op_t;

    typedef enum logic {
        REG_TOP_K       = 1'b0,
        REG_NUM_CLASSES = 1'b1
    } reg_idx_t;
endpackage
`default_nettype wire

FILE: design/tka_divider.sv
// ---------------------------------------------------------------------------
// tka_divider
// restoring divider, one quotient bit per cycle, rounded ratio in Q1.16
// ---------------------------------------------------------------------------
`default_nettype none
module tka_divider #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [COUNT_WIDTH-1:0]      hits,
    input  wire logic [COUNT_WIDTH-1:0]      total,
    output logic                             busy,
    output logic                             done,
    output logic [tka_pkg::RATIO_W-1:0]      quotient
);
    import tka_pkg::*;

    // dividend = hits*65536 + total/2, at most COUNT_WIDTH+17 bits
    localparam int DW = COUNT_WIDTH + 17;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]          dvd_reg, dvd_next;
    logic [COUNT_WIDTH:0]   rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] den_reg, den_next;
    logic [DW-1:0]          q_reg, q_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COUNT_WIDTH+1:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DW-1]};
        if (start)
        begin
            dvd_next  = {1'b0, hits, 16'd0} + DW'(total >> 1);
            rem_next  = '0;
            den_next  = total;
            q_next    = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (trial >= {2'b00, den_reg})
            begin
                rem_next = (COUNT_WIDTH+1)'(trial - {2'b00, den_reg});
                q_next   = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_WIDTH:0];
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = (den_reg == '0) ? '0 : q_reg[RATIO_W-1:0];
endmodule
`default_nettype wire

FILE: design/tka_front.sv
// ---------------------------------------------------------------------------
// tka_front
// input stage: buffers scores of a sample and queues sample and report jobs
// ---------------------------------------------------------------------------
`default_nettype none
module tka_front #(
    parameter int MAX_CLASSES = 16,
    parameter int SCORE_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        op,
    input  wire logic [15:0]                 score,
    input  wire logic [tka_pkg::FIELD_W-1:0] label,
    input  wire logic [tka_pkg::FIELD_W-1:0] ncls,
    // job queue towards the back part
    output logic                             job_valid,
    input  wire logic                        job_ready,
    output logic                             job_report,
    output logic [tka_pkg::FIELD_W-1:0]      job_label,
    output logic [tka_pkg::FIELD_W-1:0]      job_ncls,
    // score read port for the rank walk (two banks, ping-pong)
    output logic                             job_bank,
    input  wire logic [$clog2(MAX_CLASSES)-1:0] rd_addr,
    input  wire logic                        rd_bank,
    output logic signed [SCORE_WIDTH-1:0]    rd_data
);
    import tka_pkg::*;

    localparam int AW = $clog2(MAX_CLASSES);

    logic signed [SCORE_WIDTH-1:0] mem0 [MAX_CLASSES];
    logic signed [SCORE_WIDTH-1:0] mem1 [MAX_CLASSES];

    logic [FIELD_W-1:0] pos_reg, pos_next;
    logic [FIELD_W-1:0] lab_reg, lab_next;
    logic               wbank_reg, wbank_next;
    // two-entry job queue, one per bank
    logic [1:0]         qv_reg, qv_next;
    logic [1:0]         qrep_reg, qrep_next;
    logic [FIELD_W-1:0] qlab_reg [2];
    logic [FIELD_W-1:0] qnc_reg [2];
    logic               rd_ptr_reg, rd_ptr_next;
    logic               wr_ptr_reg, wr_ptr_next;

    logic               accept;
    logic [FIELD_W-1:0] pos_eff, cur_lab;
    logic               sample_end;
    logic               push, pop;

    assign pos_eff    = (pos_reg >= FIELD_W'(MAX_CLASSES)) ? '0 : pos_reg;
    assign cur_lab    = (pos_eff == '0) ? label : lab_reg;
    assign sample_end = (FIELD_W+1)'(pos_eff) + 1'b1 >= {1'b0, ncls};
    // the write bank must be free before the sample that fills it may start
    assign in_ready   = !qv_reg[wr_ptr_reg] && !(op == OP_REPORT && qv_reg != 2'b00);
    assign accept     = in_valid && in_ready;
    assign push       = accept && (op == OP_REPORT || sample_end);
    assign pop        = job_valid && job_ready;

    always_comb
    begin
        pos_next    = pos_reg;
        lab_next    = lab_reg;
        wbank_next  = wbank_reg;
        qv_next     = qv_reg;
        qrep_next   = qrep_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (pop)
        begin
            qv_next[rd_ptr_reg] = 1'b0;
            rd_ptr_next         = !rd_ptr_reg;
        end
        if (accept)
        begin
            if (op == OP_REPORT)
                pos_next = '0;
            else
            begin
                lab_next = cur_lab;
                pos_next = sample_end ? '0 : pos_eff + 1'b1;
            end
            if (push)
            begin
                qv_next[wr_ptr_reg]   = 1'b1;
                qrep_next[wr_ptr_reg] = (op == OP_REPORT);
                wr_ptr_next           = !wr_ptr_reg;
            end
        end
        wbank_next = wr_ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            lab_reg    <= '0;
            wbank_reg  <= 1'b0;
            qv_reg     <= '0;
            qrep_reg   <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            lab_reg    <= lab_next;
            wbank_reg  <= wbank_next;
            qv_reg     <= qv_next;
            qrep_reg   <= qrep_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // score kept in its low SCORE_WIDTH bits, sign taken from bit SCORE_WIDTH-1
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qlab_reg[wr_ptr_reg] <= cur_lab;
            qnc_reg[wr_ptr_reg]  <= ncls;
        end
        if (accept && op == OP_SCORE)
        begin
            if (wr_ptr_reg)
                mem1[pos_eff[AW-1:0]] <= SCORE_WIDTH'(score);
            else
                mem0[pos_eff[AW-1:0]] <= SCORE_WIDTH'(score);
        end
        rd_data <= rd_bank ? mem1[rd_addr] : mem0[rd_addr];
    end

    assign job_valid  = qv_reg[rd_ptr_reg];
    assign job_report = qrep_reg[rd_ptr_reg];
    assign job_label  = qlab_reg[rd_ptr_reg];
    assign job_ncls   = qnc_reg[rd_ptr_reg];
    assign job_bank   = rd_ptr_reg;

    `include "topk_accuracy_counter_unit_assert.svh"
    `TKA_ASSERT(a_queue_order, !(qv_reg == 2'b01 && rd_ptr_reg) && !(qv_reg == 2'b10 && !rd_ptr_reg), "job queue pointers out of order")
    `TKA_ASSERT_NEXT(a_pos_clear, accept && op == OP_REPORT, pos_reg == '0, "position not cleared by report")
    `TKA_ASSERT(a_bank_match, wbank_reg == wr_ptr_reg, "write bank lost track of queue")
endmodule
`default_nettype wire

FILE: design/tka_back.sv
// ---------------------------------------------------------------------------
// tka_back
// rank walk over a buffered sample, hit counters and report sequencing
// ---------------------------------------------------------------------------
`default_nettype none
module tka_back #(
    parameter int MAX_CLASSES = 16,
    parameter int SCORE_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [tka_pkg::FIELD_W-1:0] top_k,
    input  wire logic                        job_valid,
    output logic                             job_ready,
    input  wire logic                        job_report,
    input  wire logic [tka_pkg::FIELD_W-1:0] job_label,
    input  wire logic [tka_pkg::FIELD_W-1:0] job_ncls,
    input  wire logic                        job_bank,
    output logic [$clog2(MAX_CLASSES)-1:0]   rd_addr,
    output logic                             rd_bank,
    input  wire logic signed [SCORE_WIDTH-1:0] rd_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tka_pkg::FIELD_W-1:0]      entry,
    output logic [tka_pkg::RATIO_W-1:0]      ratio,
    output logic                             defined,
    output logic                             last
);
    import tka_pkg::*;

    localparam int AW = $clog2(MAX_CLASSES);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OWN  = 7'b0000010,
        S_WALK = 7'b0000100,
        S_TALLY= 7'b0001000,
        S_DIV  = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t             st_reg, st_next;
    logic [COUNT_WIDTH-1:0] hits_reg [MAX_CLASSES];
    logic [COUNT_WIDTH-1:0] tot_reg  [MAX_CLASSES];
    logic [COUNT_WIDTH-1:0] ohits_reg, ohits_next;
    logic [COUNT_WIDTH-1:0] ocnt_reg, ocnt_next;
    logic [FIELD_W-1:0] lab_reg, lab_next;
    logic [FIELD_W-1:0] nc_reg, nc_next;
    logic               bank_reg, bank_next;
    logic [FIELD_W:0]   j_reg, j_next;       // walk index, one ahead of data
    logic [FIELD_W:0]   jd_reg, jd_next;     // index of the score in rd_data
    logic [FIELD_W-1:0] rank_reg, rank_next;
    logic signed [SCORE_WIDTH-1:0] own_reg, own_next;
    logic [FIELD_W-1:0] ent_reg, ent_next;   // report entry being computed
    logic               last_reg, last_next;
    logic               def_reg, def_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic               ov_reg, ov_next;

    logic               div_start, div_busy, div_done;
    logic [COUNT_WIDTH-1:0] div_hits, div_tot;
    logic [RATIO_W-1:0] div_q;
    logic               lab_ok, hit;
    logic [AW-1:0]      lab_idx, cls_idx;

    assign lab_idx = lab_reg[AW-1:0];
    assign cls_idx = AW'(ent_reg - 1'b1);
    assign lab_ok  = lab_reg < nc_reg;
    assign hit     = rank_reg < top_k;

    tka_divider #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .hits(div_hits),
        .total(div_tot), .busy(div_busy), .done(div_done), .quotient(div_q)
    );

    assign div_hits = (ent_reg == '0) ? ohits_reg : hits_reg[cls_idx];
    assign div_tot  = (ent_reg == '0) ? ocnt_reg  : tot_reg[cls_idx];

    always_comb
    begin
        st_next    = st_reg;
        ohits_next = ohits_reg;
        ocnt_next  = ocnt_reg;
        lab_next   = lab_reg;
        nc_next    = nc_reg;
        bank_next  = bank_reg;
        j_next     = j_reg;
        jd_next    = jd_reg;
        rank_next  = rank_reg;
        own_next   = own_reg;
        ent_next   = ent_reg;
        last_next  = last_reg;
        def_next   = def_reg;
        ratio_next = ratio_reg;
        ov_next    = ov_reg;
        job_ready  = 1'b0;
        div_start  = 1'b0;
        rd_bank    = bank_reg;
        rd_addr    = j_reg[AW-1:0];
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_ready = 1'b1;
                    lab_next  = job_label;
                    nc_next   = job_ncls;
                    bank_next = job_bank;
                    if (job_report)
                    begin
                        ent_next = '0;
                        st_next  = S_DIV;
                    end
                    else
                    begin
                        rd_bank = job_bank;
                        rd_addr = job_label[AW-1:0];
                        st_next = S_OWN;
                    end
                end
            end
            S_OWN:
            begin
                // own score arrives; start the walk
                own_next  = rd_data;
                rank_next = '0;
                j_next    = (FIELD_W+1)'(1);
                jd_next   = '0;
                rd_addr   = '0;
                st_next   = lab_ok ? S_WALK : S_IDLE;
            end
            S_WALK:
            begin
                if (jd_reg != {1'b0, lab_reg} &&
                    (rd_data > own_reg || (rd_data == own_reg && jd_reg > {1'b0, lab_reg})))
                    rank_next = rank_reg + 1'b1;
                jd_next = jd_reg + 1'b1;
                j_next  = j_reg + 1'b1;
                if (jd_reg + 1'b1 >= {1'b0, nc_reg})
                    st_next = S_TALLY;
            end
            S_TALLY:
            begin
                if (ocnt_reg != CMAX) ocnt_next = ocnt_reg + 1'b1;
                if (hit && ohits_reg != CMAX) ohits_next = ohits_reg + 1'b1;
                st_next = S_IDLE;
            end
            S_DIV:
            begin
                if (!ov_reg || out_ready)
                begin
                    div_start = 1'b1;
                    st_next   = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    ratio_next = div_q;
                    def_next   = div_tot != '0;
                    last_next  = (ent_reg == nc_reg);
                    st_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    if (last_reg)
                    begin
                        ohits_next = '0;
                        ocnt_next  = '0;
                        st_next    = S_IDLE;
                    end
                    else
                    begin
                        ent_next = ent_reg + 1'b1;
                        st_next  = S_DIV;
                    end
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            ohits_reg <= '0;
            ocnt_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                hits_reg[i] <= '0;
                tot_reg[i]  <= '0;
            end
        end
        else
        begin
            st_reg    <= st_next;
            ohits_reg <= ohits_next;
            ocnt_reg  <= ocnt_next;
            ov_reg    <= ov_next;
            if (st_reg == S_TALLY)
            begin
                if (tot_reg[lab_idx] != CMAX)
                    tot_reg[lab_idx] <= tot_reg[lab_idx] + 1'b1;
                if (hit && hits_reg[lab_idx] != CMAX)
                    hits_reg[lab_idx] <= hits_reg[lab_idx] + 1'b1;
            end
            if (st_reg == S_OUT && !ov_reg && last_reg)
                for (int i = 0; i < MAX_CLASSES; i++)
                begin
                    hits_reg[i] <= '0;
                    tot_reg[i]  <= '0;
                end
        end
    end

    always_ff @(posedge clk)
    begin
        lab_reg   <= lab_next;
        nc_reg    <= nc_next;
        bank_reg  <= bank_next;
        j_reg     <= j_next;
        jd_reg    <= jd_next;
        rank_reg  <= rank_next;
        own_reg   <= own_next;
        ent_reg   <= ent_next;
        last_reg  <= last_next;
        def_reg   <= def_next;
        ratio_reg <= ratio_next;
    end

    // output register, loaded on the beat that the sequencer hands over
    logic [FIELD_W-1:0] oent_reg;
    logic [RATIO_W-1:0] orat_reg;
    logic               odef_reg, olast_reg;
    always_ff @(posedge clk)
    begin
        if (st_reg == S_OUT && !ov_reg)
        begin
            oent_reg  <= ent_reg;
            orat_reg  <= ratio_reg;
            odef_reg  <= def_reg;
            olast_reg <= last_reg;
        end
    end

    assign out_valid = ov_reg;
    assign entry     = oent_reg;
    assign ratio     = orat_reg;
    assign defined   = odef_reg;
    assign last      = olast_reg;

    `include "topk_accuracy_counter_unit_assert.svh"
    `TKA_ASSERT(a_hits_le_count, ohits_reg <= ocnt_reg, "overall hits above sample count")
    `TKA_ASSERT(a_ratio_range, !out_valid || orat_reg <= RATIO_W'(65536), "ratio above one")
    `TKA_ASSERT_NEXT(a_div_once, div_start, div_busy, "divider did not start")
endmodule
`default_nettype wire

FILE: design/topk_accuracy_counter_unit.sv
// ---------------------------------------------------------------------------
// topk_accuracy_counter_unit
// top-k classification accuracy counter with Q1.16 report
// ---------------------------------------------------------------------------
// input channel: in_valid/in_ready with op, score, label; a sample is
//   num_classes score beats, the label taken from the first one
// output channel: out_valid/out_ready with entry, ratio, defined, last;
//   a report beat yields 1 + classes results, overall first
// config channel: cfg_valid/cfg_ready, cfg_index 0 = top_k, 1 = num_classes;
//   always ready, write only while idle
// throughput: score beats are taken one per cycle into a two-bank buffer
//   while the write bank is free; the rank walk of a sample overlaps
//   filling of the other bank, so in a steady stream of samples the walk
//   is the bottleneck
// report: each result in turn passes through a bit-serial divider and
//   then the output register; a new division starts only after the
//   previous result is loaded into the output register
// reset: counters, position and config registers return to their
//   reset values at once; no clearing pass
// stall: a held output beat stops the report sequencer; the input side
//   keeps filling a free bank until the job queue is full
// ---------------------------------------------------------------------------
`default_nettype none
module topk_accuracy_counter_unit #(
    parameter int MAX_CLASSES = 16,
    parameter int SCORE_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [5:0]                  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        op,
    input  wire logic [15:0]                 score,
    input  wire logic [5:0]                  label,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [5:0]                       entry,
    output logic [16:0]                      ratio,
    output logic                             defined,
    output logic                             last
);
    import tka_pkg::*;

    localparam int AW = $clog2(MAX_CLASSES);

    logic [FIELD_W-1:0] topk_reg, ncls_reg;
    logic [FIELD_W-1:0] ncls_sat;

    // config registers, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topk_reg <= TOPK_RESET;
            ncls_reg <= NCLS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TOP_K:       topk_reg <= cfg_data;
                REG_NUM_CLASSES: ncls_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // classes in use, clamped to 2..MAX_CLASSES
    assign ncls_sat = (ncls_reg < FIELD_W'(2)) ? FIELD_W'(2) :
                      (ncls_reg > FIELD_W'(MAX_CLASSES)) ? FIELD_W'(MAX_CLASSES) : ncls_reg;

    logic               job_valid, job_ready, job_report, job_bank, rd_bank;
    logic [FIELD_W-1:0] job_label, job_ncls;
    logic [AW-1:0]      rd_addr;
    logic signed [SCORE_WIDTH-1:0] rd_data;

    tka_front #(.MAX_CLASSES(MAX_CLASSES), .SCORE_WIDTH(SCORE_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .score(score), .label(label), .ncls(ncls_sat),
        .job_valid(job_valid), .job_ready(job_ready), .job_report(job_report),
        .job_label(job_label), .job_ncls(job_ncls), .job_bank(job_bank),
        .rd_addr(rd_addr), .rd_bank(rd_bank), .rd_data(rd_data)
    );

    tka_back #(.MAX_CLASSES(MAX_CLASSES), .SCORE_WIDTH(SCORE_WIDTH),
               .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .top_k(topk_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job_report(job_report),
        .job_label(job_label), .job_ncls(job_ncls), .job_bank(job_bank),
        .rd_addr(rd_addr), .rd_bank(rd_bank), .rd_data(rd_data),
        .out_valid(out_valid), .out_ready(out_ready), .entry(entry),
        .ratio(ratio), .defined(defined), .last(last)
    );

    `include "topk_accuracy_counter_unit_assert.svh"
    `TKA_ASSERT(a_ncls_range, ncls_sat >= FIELD_W'(2) && ncls_sat <= FIELD_W'(MAX_CLASSES), "class count out of range")
    `TKA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(entry), "result dropped under stall")
    `TKA_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")
endmodule
`default_nettype wire
